// ===== hdl/mxr_pkg.sv =====
package mxr_pkg;

  localparam int unsigned QUEUE_DEPTH  = 8;
  localparam int unsigned NUM_PORTS    = 5;
  localparam int unsigned PAYLOAD_BITS = 32;

  localparam int unsigned COORD_W   = 5;
  localparam int unsigned RCOORD_W  = 4;
  localparam int unsigned DROP_W    = 16;
  localparam int unsigned PORT_W    = 3;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CMD_DEPTH = 2;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned SLOT_W    = 4 * COORD_W + PAYLOAD_BITS;
  localparam int unsigned S_TDATA_W = (SLOT_W + 7) / 8 * 8;
  localparam int unsigned M_TDATA_W = (SLOT_W + DROP_W + 7) / 8 * 8;
  localparam int unsigned M_TUSER_W = PORT_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_Y = CFG_IDX_W'(1);

  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [PORT_W-1:0] PORT_PE    = PORT_W'(0);
  localparam logic [PORT_W-1:0] PORT_NORTH = PORT_W'(1);
  localparam logic [PORT_W-1:0] PORT_EAST  = PORT_W'(2);
  localparam logic [PORT_W-1:0] PORT_SOUTH = PORT_W'(3);
  localparam logic [PORT_W-1:0] PORT_WEST  = PORT_W'(4);

  localparam logic [COORD_W-1:0] COORD_NONE = '1;
  localparam logic [DROP_W-1:0]  DROP_MAX   = '1;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_DROP,
    CMD_TICK
  } cmd_kind_e;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic [COORD_W-1:0]      dest_y;
    logic [COORD_W-1:0]      dest_x;
    logic [COORD_W-1:0]      src_y;
    logic [COORD_W-1:0]      src_x;
  } slot_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [PORT_W-1:0] port;
    slot_t             slot;
  } cmd_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

endpackage

// ===== hdl/mxr_ram.sv =====
module mxr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mxr_front.sv =====
module mxr_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mxr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mxr_pkg::RCOORD_W-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [mxr_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                            s_axis_tuser_i,
  output logic                            cmd_valid_o,
  input  logic                            cmd_ready_i,
  output mxr_pkg::cmd_t                   cmd_o
);
  import mxr_pkg::*;

  logic [RCOORD_W-1:0] router_x_q, router_y_q;
  slot_t               slot;
  logic                empty_slot, bad_dest;
  logic signed [COORD_W-1:0] rx, ry, dx, dy;
  logic [PORT_W-1:0]   port;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      router_x_q <= '0;
      router_y_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ROUTER_X) begin
        router_x_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_ROUTER_Y) begin
        router_y_q <= cfg_data_i;
      end
    end
  end

  assign slot       = slot_t'(s_axis_tdata_i[SLOT_W-1:0]);
  assign empty_slot = (slot.src_x == COORD_NONE) && (slot.src_y == COORD_NONE);
  assign bad_dest   = (slot.dest_x == COORD_NONE) || (slot.dest_y == COORD_NONE);

  assign rx = $signed({1'b0, router_x_q});
  assign ry = $signed({1'b0, router_y_q});
  assign dx = $signed(slot.dest_x);
  assign dy = $signed(slot.dest_y);

  // row first, then column
  always_comb begin
    priority if (dy < ry) begin
      port = PORT_NORTH;
    end else if (dy > ry) begin
      port = PORT_SOUTH;
    end else if (dx < rx) begin
      port = PORT_WEST;
    end else if (dx > rx) begin
      port = PORT_EAST;
    end else begin
      port = PORT_PE;
    end
  end

  always_comb begin
    cmd_o.slot = slot;
    cmd_o.port = port;
    priority if (s_axis_tuser_i == REQ_TICK) begin
      cmd_o.kind = CMD_TICK;
    end else if (bad_dest) begin
      cmd_o.kind = CMD_DROP;
    end else begin
      cmd_o.kind = CMD_PUSH;
    end
  end

  // empty slots are taken and discarded here
  assign cmd_valid_o     = s_axis_tvalid_i && ((s_axis_tuser_i == REQ_TICK) || !empty_slot);
  assign s_axis_tready_o = cmd_ready_i;

endmodule

// ===== hdl/mxr_cmd_fifo.sv =====
module mxr_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mxr_pkg::cmd_t in_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mxr_pkg::cmd_t out_cmd_o
);
  import mxr_pkg::*;

  localparam int unsigned CPTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CCNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t              mem_q [CMD_DEPTH];
  logic [CPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CCNT_W-1:0] count_q;
  logic              do_wr, do_rd;

  assign in_ready_o  = (count_q != CCNT_W'(CMD_DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_cmd_o   = mem_q[rd_ptr_q];
  assign do_wr       = in_valid_i && in_ready_o;
  assign do_rd       = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == CPTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + CPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == CPTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + CPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CCNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/mxr_back.sv =====
module mxr_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  input  mxr_pkg::cmd_t                   cmd_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [mxr_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  output logic [mxr_pkg::M_TUSER_W-1:0]   m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);
  import mxr_pkg::*;

  logic [PTR_W-1:0]  head_q [NUM_PORTS];
  logic [PTR_W-1:0]  tail_q [NUM_PORTS];
  logic [CNT_W-1:0]  count_q [NUM_PORTS];
  logic [SLOT_W-1:0] rdata [NUM_PORTS];
  logic [NUM_PORTS-1:0] we, re;

  logic [DROP_W-1:0] drops_q;
  logic [PORT_W-1:0] step_q;

  logic              st1_valid_q, st1_hit_q, st1_last_q;
  logic [PORT_W-1:0] st1_port_q;
  logic [DROP_W-1:0] st1_drops_q;

  logic                 out_valid_q, out_last_q;
  logic [M_TDATA_W-1:0] out_tdata_q, out_tdata_d;
  logic [M_TUSER_W-1:0] out_tuser_q;

  logic  st1_adv, issue_ok, tick_issue, step_last, is_push, full, drop_evt, push_ok;
  slot_t head_slot, empty_slot;

  assign st1_adv    = !out_valid_q || m_axis_tready_i;
  assign issue_ok   = !st1_valid_q || st1_adv;
  assign step_last  = (step_q == PORT_W'(NUM_PORTS - 1));
  assign tick_issue = cmd_valid_i && (cmd_i.kind == CMD_TICK) && issue_ok;
  assign is_push    = cmd_valid_i && (cmd_i.kind == CMD_PUSH);
  assign full       = (count_q[cmd_i.port] == CNT_W'(QUEUE_DEPTH));
  assign push_ok    = is_push && !full;
  assign drop_evt   = (cmd_valid_i && (cmd_i.kind == CMD_DROP)) || (is_push && full);

  // a tick retires when the read step for its last port is issued
  assign cmd_ready_o = (cmd_i.kind != CMD_TICK) || (issue_ok && step_last);

  for (genvar p = 0; p < NUM_PORTS; p++) begin : g_port
    assign we[p] = push_ok && (cmd_i.port == PORT_W'(p));
    assign re[p] = tick_issue && (step_q == PORT_W'(p)) && (count_q[p] != '0);

    mxr_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(QUEUE_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we[p]),
      .waddr_i(tail_q[p]),
      .wdata_i(cmd_i.slot),
      .re_i   (re[p]),
      .raddr_i(head_q[p]),
      .rdata_o(rdata[p])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        head_q[p]  <= '0;
        tail_q[p]  <= '0;
        count_q[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        if (we[p]) begin
          tail_q[p]  <= ptr_inc(tail_q[p]);
          count_q[p] <= count_q[p] + CNT_W'(1);
        end else if (re[p]) begin
          head_q[p]  <= ptr_inc(head_q[p]);
          count_q[p] <= count_q[p] - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drops_q     <= '0;
      step_q      <= PORT_PE;
      st1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (drop_evt && (drops_q != DROP_MAX)) begin
        drops_q <= drops_q + DROP_W'(1);
      end
      if (tick_issue) begin
        step_q <= step_last ? PORT_PE : step_q + PORT_W'(1);
      end
      if (issue_ok) begin
        st1_valid_q <= tick_issue;
      end
      if (st1_adv) begin
        out_valid_q <= st1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_issue) begin
      st1_port_q  <= step_q;
      st1_hit_q   <= (count_q[step_q] != '0);
      st1_drops_q <= drops_q;
      st1_last_q  <= step_last;
    end
    if (st1_valid_q && st1_adv) begin
      out_tdata_q <= out_tdata_d;
      out_tuser_q <= {st1_hit_q, st1_port_q};
      out_last_q  <= st1_last_q;
    end
  end

  always_comb begin
    empty_slot.payload = '0;
    empty_slot.dest_y  = COORD_NONE;
    empty_slot.dest_x  = COORD_NONE;
    empty_slot.src_y   = COORD_NONE;
    empty_slot.src_x   = COORD_NONE;
    head_slot          = slot_t'(rdata[st1_port_q]);
    out_tdata_d        = '0;
    out_tdata_d[SLOT_W-1:0]      = st1_hit_q ? head_slot : empty_slot;
    out_tdata_d[SLOT_W +: DROP_W] = st1_drops_q;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_tdata_q;
  assign m_axis_tuser_o  = out_tuser_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== hdl/mesh_xy_router_output_queues.sv =====
// Packets: one per cycle while the command queue has room, via that queue into the output queue.
// Ticks: five results, one per port, one per cycle unless the output stalls; a tick holds the
// back end while it steps the ports (one queue-RAM read per non-empty port). Back end and
// output stage stall independently of the front through a two-entry command queue. Reset
// clears config, queue pointers, counts and the drop counter; queue RAM is not cleared.
module mesh_xy_router_output_queues (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mxr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mxr_pkg::RCOORD_W-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // src_x, src_y, dest_x, dest_y, payload, zero pad
  input  logic [mxr_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // req_type
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // out_src_x, out_src_y, out_dest_x, out_dest_y, out_payload, drop_count, zero pad
  output logic [mxr_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // out_port, out_valid
  output logic [mxr_pkg::M_TUSER_W-1:0]   m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);
  import mxr_pkg::*;

  logic cmd_valid, cmd_ready, bk_valid, bk_ready;
  cmd_t cmd, bk_cmd;

  mxr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  mxr_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_valid),
    .in_ready_o (cmd_ready),
    .in_cmd_i   (cmd),
    .out_valid_o(bk_valid),
    .out_ready_i(bk_ready),
    .out_cmd_o  (bk_cmd)
  );

  mxr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (bk_valid),
    .cmd_ready_o    (bk_ready),
    .cmd_i          (bk_cmd),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  logic             m_take;
  logic [PORT_W-1:0] m_port;
  assign m_take = m_axis_tvalid_o && m_axis_tready_i;
  assign m_port = m_axis_tuser_o[PORT_W-1:0];

  a_last_on_west: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_port == PORT_WEST)))
    else $error("tlast not aligned with last port");

  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[PORT_W]) |->
      (m_axis_tdata_o[4*COORD_W-1:0] == '1) && (m_axis_tdata_o[SLOT_W-1:4*COORD_W] == '0))
    else $error("empty result carries data");

  a_port_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_take && !m_axis_tlast_o) |=>
      (!m_axis_tvalid_o || (m_port == $past(m_port) + PORT_W'(1))))
    else $error("port results out of order");

  a_tick_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_take && m_axis_tlast_o) |=> (!m_axis_tvalid_o || (m_port == PORT_PE)))
    else $error("tick does not start at port PE");

endmodule
